[src/hsv_pkg.sv]
package hsv_pkg;

	localparam int CHANNEL_BITS_DEF = 8;
	localparam int HUE_BITS = 9;
	localparam int SECTOR_DEG = 60;

	// Hue codes 360..511 land in sectors six to eight and share the magenta sector mux.
	localparam int LAST_SECTOR = ((1 << HUE_BITS) - 1) / SECTOR_DEG;
	localparam int SEC_W = $clog2(LAST_SECTOR + 1);

	typedef logic [SEC_W-1:0] sector_t;

	localparam sector_t SEC_RED_YELLOW     = SEC_W'(0);
	localparam sector_t SEC_YELLOW_GREEN   = SEC_W'(1);
	localparam sector_t SEC_GREEN_CYAN     = SEC_W'(2);
	localparam sector_t SEC_CYAN_BLUE      = SEC_W'(3);
	localparam sector_t SEC_BLUE_MAGENTA   = SEC_W'(4);

endpackage

[src/hsv_to_rgb_converter_top.sv]
// HSV to RGB pixel converter, five register stages deep.
// Path: an accepted input item moves through the stage 1 to stage 5 registers in order,
// and its result waits in the stage 5 output register until m_tready takes it.
// Throughput: one item per cycle while m_tready is high; every stage holds one item and
// moves on when the stage ahead is free, so an output stall fills the pipeline before s_tready drops.
// Reset (arst_n low, asynchronous) clears the valid bit of every stage; data registers keep.
module hsv_to_rgb_converter_top import hsv_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
	localparam int IN_W = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // hue_degrees, saturation, brightness
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // red, green, blue
);

	localparam int CB = CHANNEL_BITS;
	localparam int WW = 2 * CB;           // v*s product
	localparam int AW = CB + 6;           // quotient times fraction
	localparam int XW = CB + 7;           // remainder check against 60*M
	localparam int K = AW + 6;            // reciprocal shift for divide by 60
	localparam longint RECIP_VAL = ((longint'(1) << K) + SECTOR_DEG - 1) / SECTOR_DEG;
	localparam logic [AW:0] RECIP = RECIP_VAL[AW:0];
	localparam logic [CB-1:0] MAXV = {CB{1'b1}};
	localparam logic [XW-1:0] FULL = XW'(longint'(SECTOR_DEG) * ((longint'(1) << CB) - 1));

	// Handshake: each stage loads when it is empty or the stage ahead loads.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !valid_s5 || m_tready;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: sector and fraction of the hue, product v*s.
	logic [HUE_BITS-1:0] hue_in;
	logic [CB-1:0]       sat_in, val_in;
	sector_t             sec_c;
	logic [HUE_BITS-1:0] base_c;
	logic [HUE_BITS-1:0] frac_c;

	assign hue_in = s_tdata[HUE_BITS-1:0];
	assign sat_in = s_tdata[HUE_BITS +: CB];
	assign val_in = s_tdata[HUE_BITS + CB +: CB];

	always_comb begin
		sec_c = SEC_RED_YELLOW;
		base_c = '0;
		for (int k = 1; k <= LAST_SECTOR; k++) begin
			if (hue_in >= HUE_BITS'(k * SECTOR_DEG)) begin
				sec_c = SEC_W'(k);
				base_c = HUE_BITS'(k * SECTOR_DEG);
			end
		end
		frac_c = hue_in - base_c;
	end

	sector_t       sec_s1;
	logic [5:0]    f_s1;
	logic [6:0]    fc_s1;
	logic [CB-1:0] v_s1;
	logic [WW-1:0] w_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sec_s1 <= sec_c;
			f_s1   <= frac_c[5:0];
			fc_s1  <= 7'(SECTOR_DEG) - {1'b0, frac_c[5:0]};
			v_s1   <= val_in;
			w_s1   <= {{CB{1'b0}}, val_in} * {{CB{1'b0}}, sat_in};
		end
	end

	// Stage 2: w = wq*M + wr, with M = 2^CB - 1.
	logic [WW:0]   wsum_c;
	logic [CB-1:0] wq_c;
	logic [WW-1:0] wr_full_c;

	always_comb begin
		wsum_c = {1'b0, w_s1} + {{(CB + 1){1'b0}}, w_s1[WW-1:CB]} + {{WW{1'b0}}, 1'b1};
		wq_c = wsum_c[WW-1:CB];
		wr_full_c = w_s1 - ({wq_c, {CB{1'b0}}} - {{CB{1'b0}}, wq_c});
	end

	sector_t       sec_s2;
	logic [5:0]    f_s2;
	logic [6:0]    fc_s2;
	logic [CB-1:0] v_s2, wq_s2, wr_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sec_s2 <= sec_s1;
			f_s2   <= f_s1;
			fc_s2  <= fc_s1;
			v_s2   <= v_s1;
			wq_s2  <= wq_c;
			wr_s2  <= wr_full_c[CB-1:0];
		end
	end

	// Stage 3: split v*s*f/(60M) into whole and remainder parts; p is final here.
	logic [AW:0] at_full_c, bt_full_c;

	assign at_full_c = {{(AW + 1 - CB){1'b0}}, wq_s2} * {{(AW - 6){1'b0}}, fc_s2};
	assign bt_full_c = {{(AW + 1 - CB){1'b0}}, wr_s2} * {{(AW - 6){1'b0}}, fc_s2};

	sector_t       sec_s3;
	logic [CB-1:0] v_s3, p_s3;
	logic [AW-1:0] aq_s3, at_s3, bq_s3, bt_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sec_s3 <= sec_s2;
			v_s3   <= v_s2;
			p_s3   <= v_s2 - wq_s2 - CB'(wr_s2 != '0);
			aq_s3  <= {6'd0, wq_s2} * {{CB{1'b0}}, f_s2};
			bq_s3  <= {6'd0, wr_s2} * {{CB{1'b0}}, f_s2};
			at_s3  <= at_full_c[AW-1:0];
			bt_s3  <= bt_full_c[AW-1:0];
		end
	end

	// Stage 4: divide the whole parts by 60 through a reciprocal multiply.
	logic [2*AW:0] aq_prod_c, at_prod_c;

	assign aq_prod_c = {{(AW + 1){1'b0}}, aq_s3} * {{AW{1'b0}}, RECIP};
	assign at_prod_c = {{(AW + 1){1'b0}}, at_s3} * {{AW{1'b0}}, RECIP};

	sector_t       sec_s4;
	logic [CB-1:0] v_s4, p_s4, qq_s4, qt_s4;
	logic [5:0]    aq_lo_s4, at_lo_s4;
	logic [AW-1:0] bq_s4, bt_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sec_s4   <= sec_s3;
			v_s4     <= v_s3;
			p_s4     <= p_s3;
			qq_s4    <= aq_prod_c[K + CB - 1:K];
			qt_s4    <= at_prod_c[K + CB - 1:K];
			aq_lo_s4 <= aq_s3[5:0];
			at_lo_s4 <= at_s3[5:0];
			bq_s4    <= bq_s3;
			bt_s4    <= bt_s3;
		end
	end

	// Stage 5: the leftover (ar*M + b)/(60M) rounds up to 0, 1 or 2; then the sector mux.
	logic [AW-1:0] q60_c, t60_c;
	logic [5:0]    arq_c, art_c;
	logic [XW-1:0] xq_c, xt_c;
	logic [1:0]    cq_c, ct_c;
	logic [CB-1:0] q_c, t_c;
	logic [CB-1:0] red_c, green_c, blue_c;

	always_comb begin
		q60_c = {qq_s4, 6'd0} - {4'd0, qq_s4, 2'd0};
		t60_c = {qt_s4, 6'd0} - {4'd0, qt_s4, 2'd0};
		arq_c = aq_lo_s4 - q60_c[5:0];
		art_c = at_lo_s4 - t60_c[5:0];
		xq_c = {1'b0, arq_c, {CB{1'b0}}} - {{(CB + 1){1'b0}}, arq_c} + {1'b0, bq_s4};
		xt_c = {1'b0, art_c, {CB{1'b0}}} - {{(CB + 1){1'b0}}, art_c} + {1'b0, bt_s4};
		cq_c = (xq_c == '0) ? 2'd0 : ((xq_c <= FULL) ? 2'd1 : 2'd2);
		ct_c = (xt_c == '0) ? 2'd0 : ((xt_c <= FULL) ? 2'd1 : 2'd2);
		q_c = v_s4 - qq_s4 - CB'(cq_c);
		t_c = v_s4 - qt_s4 - CB'(ct_c);

		unique case (sec_s4)
			SEC_RED_YELLOW: begin
				red_c = v_s4; green_c = t_c; blue_c = p_s4;
			end
			SEC_YELLOW_GREEN: begin
				red_c = q_c; green_c = v_s4; blue_c = p_s4;
			end
			SEC_GREEN_CYAN: begin
				red_c = p_s4; green_c = v_s4; blue_c = t_c;
			end
			SEC_CYAN_BLUE: begin
				red_c = p_s4; green_c = q_c; blue_c = v_s4;
			end
			SEC_BLUE_MAGENTA: begin
				red_c = t_c; green_c = p_s4; blue_c = v_s4;
			end
			default: begin
				red_c = v_s4; green_c = p_s4; blue_c = q_c;
			end
		endcase
	end

	logic [CB-1:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			red_s5   <= red_c;
			green_s5 <= green_c;
			blue_s5  <= blue_c;
		end
	end

	assign m_tdata = OUT_W'({blue_s5, green_s5, red_s5});

	// An accepted item always lands in the first stage.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item did not reach stage 1");

	// The divide by M must leave a remainder below M.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> wr_s2 != MAXV)
		else $error("remainder of v*s by full scale out of range");

	// p never exceeds the brightness.
	a_p_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> p_s3 <= v_s3)
		else $error("p exceeds brightness");

	// A held stage keeps its item until the stage ahead takes it.
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !en_s5 |=> valid_s4 && $stable(qq_s4) && $stable(sec_s4))
		else $error("stage 4 lost its item during a stall");

endmodule
